// ----- hdl/stable_priority_queue_assert.svh -----
// Assertion macros shared by the queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue assertion failed");

// Next-cycle implication, disabled in reset.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue assertion failed");

`endif

// ----- hdl/spq_pkg.sv -----
// Types and constants for the stable priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int KEY_W = 16;
  localparam int AGE_W = 8;
  localparam int LVL_W = 2;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam logic [LVL_W-1:0] LVL_LOWEST = 2'd3;
  localparam logic [LVL_W-1:0] LVL_NONE   = 2'd0;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SERVE  = 2'd1,
    OP_SEARCH = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_PLACE,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
    logic [LVL_W-1:0] level;
  } entry_t;

  typedef struct packed {
    logic             insert_mode;
    logic             serve_mode;
    entry_t           stored;
    logic [KEY_W-1:0] key;
    logic [LVL_W-1:0] level;
  } cmp_req_t;

endpackage

// ----- hdl/spq_mem.sv -----
// Entry store: one write port, one registered read port.
`timescale 1ns / 1ps
module spq_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  spq_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output spq_pkg::entry_t rdata
);
  import spq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/spq_cmp.sv -----
// Shared compare unit: level order for insert, id match for search and remove, any entry for serve.
`timescale 1ns / 1ps
module spq_cmp (
  input  spq_pkg::cmp_req_t req,
  output logic              hit
);
  import spq_pkg::*;

  always_comb begin
    if (req.insert_mode) begin
      // stop the backward walk at an entry of equal or higher level
      hit = (req.stored.level <= req.level);
    end else begin
      hit = req.serve_mode || (req.stored.key == req.key);
    end
  end

endmodule

// ----- hdl/stable_priority_queue.sv -----
// Top level: sequencer of the stable priority queue.
`timescale 1ns / 1ps
// Stable priority queue of up to QUEUE_DEPTH entries (id, age, level 1..3).
// Request channel: a beat is taken at a rising edge with start high and busy
// low; operation selects insert, serve head, search by id or remove by id.
// Result channel: done is high for exactly one cycle with status and the
// reported entry; the receiver must take it then, it cannot stall the block.
// busy stays high from the accepted request up to and including the done
// cycle; the next request is taken in the cycle after done.
// Each request walks the stored entries through the single read port of the
// entry memory, one entry per cycle. A refused insert, or a serve, search or
// remove on an empty queue, goes straight to the result beat, and an insert
// into an empty queue makes only the placing write. Search walks from the
// head to the match or the last entry, serve and remove to the last entry;
// insert walks backward from the tail, then makes one placing write.
// Insert walks from the tail, shifting lower-level entries down by one;
// remove and serve walk from the head, shifting later entries up by one.
// Reset (rst, synchronous) empties the queue; memory contents are not
// cleared, since entries at or above the occupancy count are never read.
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [spq_pkg::OP_W-1:0]   operation,
  input  logic [spq_pkg::KEY_W-1:0]  entry_key,
  input  logic [spq_pkg::AGE_W-1:0]  entry_age,
  input  logic [spq_pkg::LVL_W-1:0]  entry_level,
  output logic                       done,
  output logic [spq_pkg::ST_W-1:0]   status,
  output logic [spq_pkg::KEY_W-1:0]  found_key,
  output logic [spq_pkg::AGE_W-1:0]  found_age,
  output logic [spq_pkg::LVL_W-1:0]  found_level
);
  import spq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  fsm_t             state, state_next;
  op_t              op_q, op_q_next;
  logic [KEY_W-1:0] key_q, key_q_next;
  logic [AGE_W-1:0] age_q, age_q_next;
  logic [LVL_W-1:0] lvl_q, lvl_q_next;
  logic [CW-1:0]    occupancy, occupancy_next;
  logic [AW-1:0]    rd_idx, rd_idx_next;
  logic             issue_on, issue_on_next;
  logic             data_vld, data_vld_next;
  logic [AW-1:0]    data_idx, data_idx_next;
  logic             found, found_next;
  entry_t           hit_entry, hit_entry_next;
  status_t          res_status, res_status_next;
  logic [AW-1:0]    wr_pos, wr_pos_next;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  entry_t           mem_wdata;
  entry_t           rdata;
  cmp_req_t         cmp_req;
  logic             cmp_hit;
  logic [AW-1:0]    last_idx;
  logic             at_last;
  logic [LVL_W-1:0] in_level;

  spq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  spq_cmp u_cmp (
    .req (cmp_req),
    .hit (cmp_hit)
  );

  assign last_idx = AW'(occupancy - CW'(1));
  assign at_last  = (data_idx == last_idx);
  assign in_level = (entry_level == LVL_NONE) ? LVL_LOWEST : entry_level;

  always_comb begin
    cmp_req.insert_mode = (op_q == OP_INSERT);
    cmp_req.serve_mode  = (op_q == OP_SERVE);
    cmp_req.stored      = rdata;
    cmp_req.key         = key_q;
    cmp_req.level       = lvl_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      issue_on  <= 1'b0;
      data_vld  <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      issue_on  <= issue_on_next;
      data_vld  <= data_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q       <= op_q_next;
    key_q      <= key_q_next;
    age_q      <= age_q_next;
    lvl_q      <= lvl_q_next;
    rd_idx     <= rd_idx_next;
    data_idx   <= data_idx_next;
    found      <= found_next;
    hit_entry  <= hit_entry_next;
    res_status <= res_status_next;
    wr_pos     <= wr_pos_next;
  end

  always_comb begin
    state_next      = state;
    op_q_next       = op_q;
    key_q_next      = key_q;
    age_q_next      = age_q;
    lvl_q_next      = lvl_q;
    occupancy_next  = occupancy;
    rd_idx_next     = rd_idx;
    issue_on_next   = issue_on;
    data_vld_next   = (state == S_WALK) && issue_on;
    data_idx_next   = rd_idx;
    found_next      = found;
    hit_entry_next  = hit_entry;
    res_status_next = res_status;
    wr_pos_next     = wr_pos;
    mem_we          = 1'b0;
    mem_waddr       = data_idx;
    mem_wdata       = rdata;

    case (state)
      S_IDLE: begin
        issue_on_next = 1'b0;
        if (start) begin
          op_q_next       = op_t'(operation);
          key_q_next      = entry_key;
          age_q_next      = entry_age;
          lvl_q_next      = in_level;
          found_next      = 1'b0;
          hit_entry_next  = '0;
          res_status_next = ST_OK;
          if (op_t'(operation) == OP_INSERT) begin
            if (occupancy == CW'(QUEUE_DEPTH)) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else if (occupancy == '0) begin
              wr_pos_next = '0;
              state_next  = S_PLACE;
            end else begin
              rd_idx_next   = last_idx;
              issue_on_next = 1'b1;
              state_next    = S_WALK;
            end
          end else begin
            if (occupancy == '0) begin
              res_status_next = (op_t'(operation) == OP_SERVE) ? ST_EMPTY : ST_NOT_FOUND;
              state_next      = S_DONE;
            end else begin
              rd_idx_next   = '0;
              issue_on_next = 1'b1;
              state_next    = S_WALK;
            end
          end
        end
      end

      S_WALK: begin
        // read issue, one entry a cycle
        if (issue_on) begin
          if (op_q == OP_INSERT) begin
            if (rd_idx == '0) begin
              issue_on_next = 1'b0;
            end else begin
              rd_idx_next = rd_idx - AW'(1);
            end
          end else begin
            if (rd_idx == last_idx) begin
              issue_on_next = 1'b0;
            end else begin
              rd_idx_next = rd_idx + AW'(1);
            end
          end
        end
        // entry returned by the memory
        if (data_vld) begin
          if (op_q == OP_INSERT) begin
            if (cmp_hit) begin
              wr_pos_next   = data_idx + AW'(1);
              issue_on_next = 1'b0;
              state_next    = S_PLACE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = data_idx + AW'(1);
              if (data_idx == '0) begin
                wr_pos_next   = '0;
                issue_on_next = 1'b0;
                state_next    = S_PLACE;
              end
            end
          end else if (found) begin
            mem_we    = 1'b1;
            mem_waddr = data_idx - AW'(1);
            if (at_last) begin
              occupancy_next  = occupancy - CW'(1);
              res_status_next = ST_OK;
              issue_on_next   = 1'b0;
              state_next      = S_DONE;
            end
          end else if (cmp_hit) begin
            hit_entry_next = rdata;
            if (op_q == OP_SEARCH) begin
              res_status_next = ST_OK;
              issue_on_next   = 1'b0;
              state_next      = S_DONE;
            end else begin
              found_next = 1'b1;
              if (at_last) begin
                occupancy_next  = occupancy - CW'(1);
                res_status_next = ST_OK;
                issue_on_next   = 1'b0;
                state_next      = S_DONE;
              end
            end
          end else if (at_last) begin
            res_status_next = ST_NOT_FOUND;
            issue_on_next   = 1'b0;
            state_next      = S_DONE;
          end
        end
      end

      S_PLACE: begin
        mem_we          = 1'b1;
        mem_waddr       = wr_pos;
        mem_wdata.key   = key_q;
        mem_wdata.age   = age_q;
        mem_wdata.level = lvl_q;
        occupancy_next  = occupancy + CW'(1);
        res_status_next = ST_OK;
        state_next      = S_DONE;
      end

      S_DONE: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy        = (state != S_IDLE);
  assign done        = (state == S_DONE);
  assign status      = res_status;
  assign found_key   = hit_entry.key;
  assign found_age   = hit_entry.age;
  assign found_level = hit_entry.level;

`include "stable_priority_queue_assert.svh"

  `SPQ_ASSERT_NOW(a_occ_bound, clk, rst, 1'b1, occupancy <= CW'(QUEUE_DEPTH))
  `SPQ_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `SPQ_ASSERT_NEXT(a_idle_occ_hold, clk, rst, state == S_IDLE, $stable(occupancy))
  `SPQ_ASSERT_NOW(a_no_entry_on_fail, clk, rst, done && status != ST_OK, found_level == LVL_NONE && found_key == '0)
  `SPQ_ASSERT_NOW(a_write_in_walk, clk, rst, mem_we, state == S_WALK || state == S_PLACE)

endmodule

// ----- bench/queue_watch.sv -----
// Request and result monitor for the stable priority queue: predicts and compares every reply.
`timescale 1ns / 1ps
module queue_watch #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [spq_pkg::OP_W-1:0]  operation,
  input  logic [spq_pkg::KEY_W-1:0] entry_key,
  input  logic [spq_pkg::AGE_W-1:0] entry_age,
  input  logic [spq_pkg::LVL_W-1:0] entry_level,
  input  logic                      done,
  input  logic [spq_pkg::ST_W-1:0]  status,
  input  logic [spq_pkg::KEY_W-1:0] found_key,
  input  logic [spq_pkg::AGE_W-1:0] found_age,
  input  logic [spq_pkg::LVL_W-1:0] found_level,
  output int                        errors,
  output int                        outstanding
);
  import spq_pkg::*;

  typedef struct packed {
    status_t status;
    entry_t  entry;
  } reply_t;

  entry_t slots [DEPTH];
  int     fill;
  reply_t replies_due [$];

  task automatic drop_slot(input int at);
    int i;
    for (i = at; i + 1 < fill; i++) slots[i] = slots[i + 1];
    fill--;
  endtask

  task automatic serve_request(input op_t op, input logic [KEY_W-1:0] key,
                               input logic [AGE_W-1:0] age, input logic [LVL_W-1:0] level,
                               output reply_t r);
    int pos;
    int i;
    bit hit;
    logic [LVL_W-1:0] lvl;
    r = '{status: ST_OK, entry: '0};
    case (op)
      OP_INSERT: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          lvl = (level == LVL_NONE) ? LVL_LOWEST : level;
          pos = 0;
          while (pos < fill && slots[pos].level <= lvl) pos++;
          for (i = fill; i > pos; i--) slots[i] = slots[i - 1];
          slots[pos] = '{key: key, age: age, level: lvl};
          fill++;
        end
      end
      OP_SERVE: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.entry = slots[0];
          drop_slot(0);
        end
      end
      default: begin
        hit = 1'b0;
        pos = 0;
        for (i = 0; i < fill && !hit; i++) begin
          if (slots[i].key == key) begin
            hit = 1'b1;
            pos = i;
          end
        end
        if (!hit) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.entry = slots[pos];
          if (op == OP_REMOVE) drop_slot(pos);
        end
      end
    endcase
  endtask

  task automatic flag(input string what, input logic [KEY_W-1:0] want,
                      input logic [KEY_W-1:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      fill = 0;
      replies_due.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result beat with none due, expected nothing, got status %h key %h",
                   $time, status, found_key);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (status !== want.status)
            flag("status", KEY_W'(want.status), KEY_W'(status));
          if (found_key !== want.entry.key) flag("found_key", want.entry.key, found_key);
          if (found_age !== want.entry.age)
            flag("found_age", KEY_W'(want.entry.age), KEY_W'(found_age));
          if (found_level !== want.entry.level)
            flag("found_level", KEY_W'(want.entry.level), KEY_W'(found_level));
        end
      end
      if (start && !busy) begin
        serve_request(op_t'(operation), entry_key, entry_age, entry_level, want);
        replies_due.push_back(want);
      end
    end
    outstanding = replies_due.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Testbench top for the stable priority queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import spq_pkg::*;

  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RING        = 32;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [OP_W-1:0]  operation;
  logic [KEY_W-1:0] entry_key;
  logic [AGE_W-1:0] entry_age;
  logic [LVL_W-1:0] entry_level;
  logic             done;
  logic [ST_W-1:0]  status;
  logic [KEY_W-1:0] found_key;
  logic [AGE_W-1:0] found_age;
  logic [LVL_W-1:0] found_level;
  int               errors;
  int               outstanding;

  int               cycles;
  bit               idling;
  logic [KEY_W-1:0] keyring [RING];
  int               ring_n;

  stable_priority_queue #(.QUEUE_DEPTH(DEPTH)) uut (.*);
  queue_watch #(.DEPTH(DEPTH)) watch (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One request beat; start stays high until the block takes it.
  task automatic issue(input op_t op, input logic [KEY_W-1:0] key,
                       input logic [AGE_W-1:0] age, input logic [LVL_W-1:0] lvl);
    int gap;
    @(negedge clk);
    if (idling && $urandom_range(99) < 28) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3);
      start       <= 1'b0;
      operation   <= OP_W'($urandom);
      entry_key   <= KEY_W'($urandom);
      entry_age   <= AGE_W'($urandom);
      entry_level <= LVL_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    operation   <= op;
    entry_key   <= key;
    entry_age   <= age;
    entry_level <= lvl;
    do @(posedge clk); while (busy);
    if (op == OP_INSERT) begin
      keyring[ring_n % RING] = key;
      ring_n++;
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input bit reuse);
    int span;
    span = (ring_n < RING) ? ring_n : RING;
    if (reuse && span > 0 && $urandom_range(3) != 0) return keyring[$urandom_range(span - 1)];
    if ($urandom_range(1) == 1) return KEY_W'($urandom_range(15));
    return KEY_W'($urandom);
  endfunction

  initial begin
    int seg;
    int ins_pct;
    op_t op;
    logic [LVL_W-1:0] lvl;
    rst         = 1'b1;
    start       = 1'b0;
    operation   = OP_INSERT;
    entry_key   = '0;
    entry_age   = '0;
    entry_level = '0;
    ring_n      = 0;
    idling      = 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // empty queue corners
    issue(OP_SERVE,  16'h0000, 8'h00, 2'd1);
    issue(OP_SEARCH, 16'hffff, 8'hff, 2'd3);
    issue(OP_REMOVE, 16'h0000, 8'h00, 2'd2);
    // level ordering, duplicates, level 0 falls to lowest
    issue(OP_INSERT, 16'hffff, 8'hff, 2'd3);
    issue(OP_INSERT, 16'h0000, 8'h00, 2'd1);
    issue(OP_INSERT, 16'h1234, 8'h55, 2'd2);
    issue(OP_INSERT, 16'h1234, 8'haa, 2'd2);
    issue(OP_INSERT, 16'h0007, 8'h3c, 2'd0);
    issue(OP_INSERT, 16'h00a5, 8'hc3, 2'd1);
    issue(OP_SEARCH, 16'h1234, 8'h00, 2'd0);
    issue(OP_SEARCH, 16'h9999, 8'h00, 2'd0);
    issue(OP_REMOVE, 16'h1234, 8'h00, 2'd0);
    issue(OP_SEARCH, 16'h1234, 8'h00, 2'd0);
    issue(OP_REMOVE, 16'h0007, 8'h00, 2'd0);
    issue(OP_REMOVE, 16'h5a5a, 8'h00, 2'd0);
    issue(OP_SERVE,  16'h0000, 8'h00, 2'd0);
    issue(OP_SERVE,  16'h0000, 8'h00, 2'd0);
    issue(OP_SERVE,  16'h0000, 8'h00, 2'd0);
    issue(OP_SEARCH, 16'hffff, 8'h00, 2'd0);
    issue(OP_SERVE,  16'h0000, 8'h00, 2'd0);
    issue(OP_SERVE,  16'h0000, 8'h00, 2'd0);

    @(negedge clk);
    start <= 1'b0;
    wait (outstanding == 0);

    // insert-heavy segments fill the queue, insert-light ones drain it
    for (seg = 0; seg < 19; seg++) begin
      case (seg % 6)
        0, 1:    ins_pct = 90;
        3, 4:    ins_pct = 10;
        default: ins_pct = 50;
      endcase
      idling = !(seg == 7 || seg == 8);
      if (seg == 11) begin
        @(negedge clk);
        start <= 1'b0;
        wait (outstanding == 0);
      end
      repeat (50) begin
        op  = ($urandom_range(99) < ins_pct) ? OP_INSERT : op_t'($urandom_range(1, 3));
        lvl = ($urandom_range(9) == 0) ? LVL_NONE : LVL_W'($urandom_range(1, 3));
        issue(op, pick_key(op != OP_INSERT), AGE_W'($urandom), lvl);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait (outstanding == 0);
    repeat (70) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
